@@ design/crb_pkg.sv @@
package crb_pkg;

	localparam int BLOCK_BYTES = 16384;
	localparam int AW          = $clog2(BLOCK_BYTES);
	localparam int MEM_AW      = AW + 1;
	localparam int MEM_DEPTH   = 2 * BLOCK_BYTES;
	localparam int Q_DEPTH     = 4;
	localparam int Q_AW        = $clog2(Q_DEPTH);
	localparam int IN_W        = 72;
	localparam int OUT_W       = 24;

	typedef enum logic [1:0] {
		OP_HEADER = 2'd0,
		OP_DATA   = 2'd1,
		OP_READ   = 2'd2,
		OP_UNUSED = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_HDR_OK   = 3'd0,
		ST_HDR_REJ  = 3'd1,
		ST_STORED   = 3'd2,
		ST_COMPLETE = 3'd3,
		ST_STRAY    = 3'd4,
		ST_READ     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MOP_NONE  = 2'd0,
		MOP_WRITE = 2'd1,
		MOP_READ  = 2'd2
	} mop_t;

	typedef struct packed {
		status_t             status;
		mop_t                mop;
		logic [MEM_AW-1:0]   addr;
		logic [7:0]          wdata;
		logic                in_range;
		logic [AW-1:0]       clen;
		logic                cvalid;
	} entry_t;

endpackage

@@ design/crb_front.sv @@
module crb_front
	import crb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      opcode,
	input  logic [15:0]     chunk_offset,
	input  logic [15:0]     block_total,
	input  logic [15:0]     chunk_size,
	input  logic [7:0]      data_byte,
	input  logic [AW-1:0]   read_address,
	input  logic            q_full,
	output logic            push,
	output entry_t          entry
);

	localparam logic [16:0] LIMIT = 17'(BLOCK_BYTES);

	logic          bank_q, bank_d;
	logic [AW-1:0] blen_q, blen_d;
	logic          active_q, active_d;
	logic [AW-1:0] dlen_q, dlen_d;
	logic          dvalid_q, dvalid_d;
	logic [AW-1:0] wp_q, wp_d;
	logic [AW-1:0] pend_q, pend_d;
	logic          final_q, final_d;

	logic [16:0] end_pos;
	logic        bad;
	logic        hdr_final;
	opcode_t     op;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;
	assign op       = opcode_t'(opcode);
	assign end_pos  = {1'b0, chunk_offset} + {1'b0, chunk_size};
	assign hdr_final = end_pos == {1'b0, block_total};
	assign bad = ({1'b0, block_total} >= LIMIT) || (chunk_offset > block_total) ||
		(chunk_size > block_total) || (end_pos > {1'b0, block_total}) ||
		((chunk_offset != 16'd0) &&
		 (!active_q || (block_total != {{(16-AW){1'b0}}, blen_q})));

	always_comb begin
		bank_d   = bank_q;
		blen_d   = blen_q;
		active_d = active_q;
		dlen_d   = dlen_q;
		dvalid_d = dvalid_q;
		wp_d     = wp_q;
		pend_d   = pend_q;
		final_d  = final_q;
		entry.status   = ST_STRAY;
		entry.mop      = MOP_NONE;
		entry.addr     = {bank_q, read_address};
		entry.wdata    = data_byte;
		entry.in_range = 1'b0;
		unique case (op)
			OP_HEADER: begin
				if (bad) begin
					active_d = 1'b0;
					blen_d   = '0;
					pend_d   = '0;
					final_d  = 1'b0;
					entry.status = ST_HDR_REJ;
				end else begin
					if (chunk_offset == 16'd0) begin
						blen_d   = block_total[AW-1:0];
						active_d = 1'b1;
					end
					wp_d    = chunk_offset[AW-1:0];
					pend_d  = chunk_size[AW-1:0];
					final_d = hdr_final;
					entry.status = ST_HDR_OK;
					if ((chunk_size == 16'd0) && hdr_final) begin
						final_d  = 1'b0;
						bank_d   = ~bank_q;
						dlen_d   = blen_d;
						dvalid_d = 1'b1;
						blen_d   = '0;
						active_d = 1'b0;
						entry.status = ST_COMPLETE;
					end
				end
			end
			OP_DATA: begin
				if (pend_q != '0) begin
					entry.mop  = MOP_WRITE;
					entry.addr = {~bank_q, wp_q};
					wp_d   = wp_q + 1'b1;
					pend_d = pend_q - 1'b1;
					entry.status = ST_STORED;
					if ((pend_q == AW'(1)) && final_q) begin
						final_d  = 1'b0;
						bank_d   = ~bank_q;
						dlen_d   = blen_q;
						dvalid_d = 1'b1;
						blen_d   = '0;
						active_d = 1'b0;
						entry.status = ST_COMPLETE;
					end
				end
			end
			OP_READ: begin
				entry.status   = ST_READ;
				entry.mop      = MOP_READ;
				entry.in_range = dvalid_q && (read_address < dlen_q);
			end
			default: begin
				entry.status = ST_STRAY;
			end
		endcase
		entry.clen   = dlen_d;
		entry.cvalid = dvalid_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 1'b0;
			blen_q   <= '0;
			active_q <= 1'b0;
			dlen_q   <= '0;
			dvalid_q <= 1'b0;
			wp_q     <= '0;
			pend_q   <= '0;
			final_q  <= 1'b0;
		end else if (push) begin
			bank_q   <= bank_d;
			blen_q   <= blen_d;
			active_q <= active_d;
			dlen_q   <= dlen_d;
			dvalid_q <= dvalid_d;
			wp_q     <= wp_d;
			pend_q   <= pend_d;
			final_q  <= final_d;
		end
	end

endmodule

@@ design/crb_queue.sv @@
module crb_queue
	import crb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t pop_entry,
	output logic   empty
);

	entry_t        slots_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   count_q;

	assign full      = count_q == (Q_AW+1)'(Q_DEPTH);
	assign empty     = count_q == '0;
	assign pop_entry = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");
	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count mismatch");

endmodule

@@ design/crb_back.sv @@
module crb_back
	import crb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  entry_t        q_entry,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [2:0]    status,
	output logic [7:0]    read_data,
	output logic [AW-1:0] committed_length,
	output logic          committed_valid
);

	logic [7:0]    mem [MEM_DEPTH];
	logic [7:0]    rdata_q;
	logic          valid_q;
	status_t       status_q;
	logic          in_range_q;
	logic [AW-1:0] clen_q;
	logic          cvalid_q;
	logic          adv;

	assign adv = !valid_q || out_ready;
	assign pop = adv && !q_empty;

	always_ff @(posedge clk) begin
		if (pop && (q_entry.mop == MOP_WRITE)) begin
			mem[q_entry.addr] <= q_entry.wdata;
		end
		if (pop && (q_entry.mop == MOP_READ)) begin
			rdata_q <= mem[q_entry.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q   <= q_entry.status;
			in_range_q <= q_entry.in_range;
			clen_q     <= q_entry.clen;
			cvalid_q   <= q_entry.cvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid        = valid_q;
	assign status           = status_q;
	assign read_data        = in_range_q ? rdata_q : 8'd0;
	assign committed_length = clen_q;
	assign committed_valid  = cvalid_q;

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |-> !pop)
		else $error("result overwritten while stalled");
	a_rdata_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && in_range_q) |-> status_q == ST_READ)
		else $error("read data on non-read result");
	a_valid_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q) else $error("popped entry lost");

endmodule

@@ design/chunked_block_reassembler_core.sv @@
// Chunked block reassembler.
// Slave stream s_*: one beat per item, s_tuser carries the opcode (header,
// data byte, read). Master stream m_*: one result beat per item, in order,
// m_tuser carries the status.
// A header beat checks offset, total and size and arms the write pointer; the
// data beats land in the spare bank of a two-bank byte store, and the last byte
// of the final chunk, or a final empty chunk, swaps banks and commits the block.
// Read beats return bytes of the committed block.
// Throughput: one beat per cycle in each direction while s_tready and m_tready
// are high, set by at most one write or read of the byte store per beat.
// Results are registered in the back after each beat passes through the queue.
// A four-entry queue between the classifying front and the memory back lets
// the slave side keep taking beats while the master side stalls; s_tready
// drops only when the queue is full.
// Reset clears all control state: no block is built or committed. The byte
// store is not cleared; holes in the committed block read back stale bytes.
module chunked_block_reassembler_core
	import crb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// chunk_offset[15:0], block_total[31:16], chunk_size[47:32],
	// data_byte[55:48], read_address[69:56], zero pad[71:70]
	input  logic [IN_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// read_data[7:0], committed_length[21:8], committed_valid[22], zero pad[23]
	output logic [OUT_W-1:0] m_tdata,
	// status[2:0]
	output logic [2:0]       m_tuser
);

	logic          push, q_full, q_empty, pop;
	entry_t        push_entry, pop_entry;
	logic [7:0]    read_data;
	logic [AW-1:0] committed_length;
	logic          committed_valid;

	crb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.opcode       (s_tuser),
		.chunk_offset (s_tdata[15:0]),
		.block_total  (s_tdata[31:16]),
		.chunk_size   (s_tdata[47:32]),
		.data_byte    (s_tdata[55:48]),
		.read_address (s_tdata[56 +: AW]),
		.q_full       (q_full),
		.push         (push),
		.entry        (push_entry)
	);

	crb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	crb_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_empty          (q_empty),
		.q_entry          (pop_entry),
		.pop              (pop),
		.out_valid        (m_tvalid),
		.out_ready        (m_tready),
		.status           (m_tuser),
		.read_data        (read_data),
		.committed_length (committed_length),
		.committed_valid  (committed_valid)
	);

	assign m_tdata = {1'b0, committed_valid, committed_length, read_data};

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import crb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  rdata;
		logic [13:0] clen;
		logic        cval;
	} result_t;

	class reassembly_scoreboard;
		bit [7:0]    bank_mem [MEM_DEPTH];
		int unsigned fill_tag [MEM_DEPTH];
		int unsigned bank_tag [2];
		int unsigned tag_seq;
		bit          live_bank;
		bit [13:0]   build_len;
		bit          building;
		bit [13:0]   done_len;
		bit          done_ok;
		bit [15:0]   wr_ptr;
		bit [15:0]   pending;
		bit          last_chunk;
		result_t     due_results[$];
		int          checked;
		int          errors;

		function new();
			tag_seq    = 0;
			bank_tag   = '{0, 0};
			live_bank  = 0;
			build_len  = 0;
			building   = 0;
			done_len   = 0;
			done_ok    = 0;
			wr_ptr     = 0;
			pending    = 0;
			last_chunk = 0;
			checked    = 0;
			errors     = 0;
		endfunction

		function void commit_block();
			live_bank = !live_bank;
			done_len  = build_len;
			done_ok   = 1;
			build_len = 0;
			building  = 0;
		endfunction

		function status_t take_header(logic [15:0] off, logic [15:0] total, logic [15:0] size);
			logic [16:0] span;
			span = {1'b0, off} + {1'b0, size};
			if (total >= BLOCK_BYTES || off > total || size > total || span > total ||
					(off != 0 && (!building || total != build_len))) begin
				building   = 0;
				build_len  = 0;
				pending    = 0;
				last_chunk = 0;
				return ST_HDR_REJ;
			end
			if (off == 0) begin
				build_len = total[13:0];
				building  = 1;
				tag_seq++;
				bank_tag[!live_bank] = tag_seq;
			end
			wr_ptr     = off;
			pending    = size;
			last_chunk = (span == {1'b0, total});
			if (size == 0 && last_chunk) begin
				last_chunk = 0;
				commit_block();
				return ST_COMPLETE;
			end
			return ST_HDR_OK;
		endfunction

		function status_t store_byte(logic [7:0] b);
			int idx;
			if (pending == 0)
				return ST_STRAY;
			if (wr_ptr < BLOCK_BYTES) begin
				idx = (live_bank ? 0 : BLOCK_BYTES) + int'(wr_ptr);
				bank_mem[idx] = b;
				fill_tag[idx] = bank_tag[!live_bank];
			end
			wr_ptr++;
			pending--;
			if (pending == 0 && last_chunk) begin
				last_chunk = 0;
				commit_block();
				return ST_COMPLETE;
			end
			return ST_STORED;
		endfunction

		// true unless the address hits a hole in the committed block
		function bit read_safe(logic [13:0] a);
			int idx;
			idx = (live_bank ? BLOCK_BYTES : 0) + int'(a);
			return !done_ok || a >= done_len || fill_tag[idx] == bank_tag[live_bank];
		endfunction

		function void note_beat(opcode_t op, logic [15:0] off, logic [15:0] total,
				logic [15:0] size, logic [7:0] b, logic [13:0] addr);
			result_t r;
			r.rdata = '0;
			case (op)
				OP_HEADER: r.status = take_header(off, total, size);
				OP_DATA:   r.status = store_byte(b);
				OP_READ: begin
					r.status = ST_READ;
					if (done_ok && addr < done_len)
						r.rdata = bank_mem[(live_bank ? BLOCK_BYTES : 0) + int'(addr)];
				end
				default:   r.status = ST_STRAY;
			endcase
			r.clen = done_len;
			r.cval = done_ok;
			due_results.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report($sformatf("result beat with nothing expected, status %0d", got.status));
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (got.status !== want.status)
				report($sformatf("beat %0d status %0d, want %0d", checked, got.status, want.status));
			if (got.rdata !== want.rdata)
				report($sformatf("beat %0d read_data %0h, want %0h", checked, got.rdata, want.rdata));
			if (got.clen !== want.clen)
				report($sformatf("beat %0d committed_length %0d, want %0d", checked, got.clen,
					want.clen));
			if (got.cval !== want.cval)
				report($sformatf("beat %0d committed_valid %0b, want %0b", checked, got.cval,
					want.cval));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic [1:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic [2:0]        m_tuser;

	reassembly_scoreboard sb = new();
	int items;
	int burst;

	chunked_block_reassembler_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send(input opcode_t op, input logic [15:0] off, input logic [15:0] total,
			input logic [15:0] size, input logic [7:0] b, input logic [13:0] addr);
		int gap;
		if (burst > 0) begin
			burst--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 14);
			if ($urandom_range(0, 29) == 0)
				burst = $urandom_range(20, 50);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, addr, b, size, total, off};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		items++;
		sb.note_beat(op, off, total, size, b, addr);
	endtask

	task automatic hdr(input int o, input int t, input int s);
		send(OP_HEADER, 16'(o), 16'(t), 16'(s), 8'($urandom), 14'($urandom));
	endtask

	task automatic dat(input int b);
		send(OP_DATA, 16'($urandom), 16'($urandom), 16'($urandom), 8'(b), 14'($urandom));
	endtask

	task automatic rd(input int a);
		send(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 14'(a));
	endtask

	task automatic stray_op();
		send(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
			14'($urandom));
	endtask

	// steer reads away from holes in the committed block
	task automatic rd_pick();
		logic [13:0] a;
		int tries;
		tries = 0;
		a = 14'($urandom);
		if ($urandom_range(0, 2) != 0 && sb.done_ok && sb.done_len != 0)
			a = 14'($urandom_range(0, int'(sb.done_len) - 1));
		while (!sb.read_safe(a) && tries < 16) begin
			a = 14'($urandom_range(0, int'(sb.done_len) - 1));
			tries++;
		end
		if (!sb.read_safe(a))
			a = sb.done_len;
		rd(int'(a));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.due_results.size() != 0);
	endtask

	task automatic noise();
		case ($urandom_range(0, 5))
			0: hdr($urandom, $urandom, $urandom);
			1: hdr($urandom_range(0, 16383), $urandom_range(0, 16383), $urandom_range(0, 16383));
			2: dat($urandom);
			3: stray_op();
			default: rd_pick();
		endcase
	endtask

	task automatic send_block();
		int total, pos, sz, sent, cap, mode;
		mode = $urandom_range(0, 19);
		if (mode == 19)
			total = $urandom_range(200, 400);
		else if ($urandom_range(0, 9) == 0)
			total = 0;
		else
			total = $urandom_range(1, 40);
		cap = (mode == 19) ? 64 : 12;
		pos = 0;
		if (total == 0)
			hdr(0, 0, 0);
		while (pos < total) begin
			sz = (total - pos < cap) ? total - pos : cap;
			sz = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, sz);
			// commit through an empty chunk at the end, leaving the tail unwritten
			if (mode == 17 && pos > 0 && pos + sz == total) begin
				hdr(total, total, 0);
				return;
			end
			hdr(pos, total, sz);
			sent = (mode == 16 && sz > 1) ? sz - 1 : sz;
			if (sent != sz)
				mode = 0;
			repeat (sent) begin
				if ($urandom_range(0, 15) == 0)
					rd_pick();
				dat($urandom);
			end
			pos += sz;
			if (pos < total) begin
				if (mode == 14 || mode == 15) begin
					hdr(pos, total + 1, 1);
					repeat ($urandom_range(1, 3)) dat($urandom);
					return;
				end
				if (mode == 18 && $urandom_range(0, 2) == 0)
					return;
				if ($urandom_range(0, 7) == 0)
					rd_pick();
			end
		end
		if ($urandom_range(0, 3) == 0)
			rd_pick();
	endtask

	initial begin
		int stall, hold, quiet;
		bit held_once;
		result_t got;
		stall = 0;
		hold = 0;
		quiet = 0;
		held_once = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.status = m_tuser;
				got.rdata  = m_tdata[7:0];
				got.clen   = m_tdata[21:8];
				got.cval   = m_tdata[22];
				sb.check_result(got);
				if (quiet > 0) begin
					quiet--;
					stall = 0;
				end else begin
					stall = $urandom_range(0, 14);
					if ($urandom_range(0, 49) == 0)
						quiet = $urandom_range(20, 60);
				end
				// hold off long enough to back up the input
				if (!held_once && sb.checked == 250) begin
					hold = 150;
					held_once = 1;
				end
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		bit paused;
		paused = 0;
		items = 0;
		burst = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rd(0);
		dat(8'h77);
		stray_op();
		hdr(16'hffff, 16'hffff, 16'hffff);
		hdr(0, 0, 0);
		hdr(0, 4, 2);
		dat(8'h00);
		hdr(0, 4, 4);
		dat(8'hff);
		dat(8'ha5);
		dat(8'h5a);
		dat(8'h3c);
		rd(3);
		rd(4);
		hdr(0, 16383, 3);
		dat(8'h01);
		dat(8'h80);
		dat(8'h7e);
		hdr(16383, 16383, 0);
		rd(2);
		rd(16383);
		hdr(1, 16383, 1);
		hdr(0, 16384, 0);

		while (items < 850) begin
			if (!paused && items >= 500) begin
				drain();
				paused = 1;
			end
			if ($urandom_range(0, 3) == 0)
				noise();
			else
				send_block();
		end
		s_tvalid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.due_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
